>>> design/encoder_speed_stall_monitor_defines.svh
// ----------------------------------------------------------------------------
// encoder speed and stall monitor assertion macros
// shared property forms for the checker of the monitor
// ----------------------------------------------------------------------------
`ifndef ENCODER_SPEED_STALL_MONITOR_DEFINES_SVH
`define ENCODER_SPEED_STALL_MONITOR_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define ESSM_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("essm same-cycle check failed");

// consequent checked in the cycle after the antecedent
`define ESSM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("essm next-cycle check failed");

`endif

>>> design/essm_pkg.sv
// ----------------------------------------------------------------------------
// essm_pkg
// types and fixed constants of the encoder speed and stall monitor
// ----------------------------------------------------------------------------
package essm_pkg;

   // speed scale: counts per tick times this, over counts per revolution
   localparam int unsigned RPM_SCALE   = 6000;
   localparam int unsigned SCALE_WIDTH = 13;
   localparam logic [15:0] RPM_MAX     = 16'hFFFF;

   localparam logic [7:0] CHECK_MAX = 8'hFF;

   localparam logic [1:0] DIR_STOP = 2'd0;

   // register indexes
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam logic [2:0] CSR_PULSES_PER_REV    = 3'd0;
   localparam logic [2:0] CSR_STALL_MIN_PWM     = 3'd1;
   localparam logic [2:0] CSR_STALL_CHECKS      = 3'd2;
   localparam logic [2:0] CSR_DIR_CHECKS        = 3'd3;
   localparam logic [2:0] CSR_STALL_GRACE_TICKS = 3'd4;
   localparam logic [2:0] CSR_DIR_GRACE_TICKS   = 3'd5;

   // register reset values
   localparam logic [15:0] RST_PULSES_PER_REV    = 16'd1024;
   localparam logic [15:0] RST_STALL_MIN_PWM     = 16'd10;
   localparam logic [7:0]  RST_STALL_CHECKS      = 8'd50;
   localparam logic [7:0]  RST_DIR_CHECKS        = 8'd5;
   localparam logic [7:0]  RST_STALL_GRACE_TICKS = 8'd20;
   localparam logic [7:0]  RST_DIR_GRACE_TICKS   = 8'd10;

   typedef struct packed {
      logic [31:0] encoder_count;
      logic [1:0]  shaft_dir;
      logic [1:0]  drive_dir;
      logic [15:0] pwm_echo;
   } req_type;

   typedef struct packed {
      logic [15:0] speed_rpm;
      logic [1:0]  measured_dir;
      logic        stall_fault;
      logic        direction_fault;
      logic        motor_enable;
   } rsp_type;

endpackage

>>> design/essm_div.sv
// ----------------------------------------------------------------------------
// essm_div
// bit-serial restoring divider, one dividend bit per cycle, 16-bit saturated
// quotient
// ----------------------------------------------------------------------------
module essm_div #(
   parameter int DIVIDEND_WIDTH = 45
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [DIVIDEND_WIDTH-1:0] dividend,
   input  logic [15:0]               divisor,
   output logic                      done,
   output logic [15:0]               quotient
);

   localparam int CNT_WIDTH = $clog2(DIVIDEND_WIDTH + 1);

   logic                      busy_ff, busy_in;
   logic                      done_ff, done_in;
   logic [CNT_WIDTH-1:0]      cnt_ff, cnt_in;
   logic [DIVIDEND_WIDTH-1:0] num_ff, num_in;
   logic [15:0]               rem_ff, rem_in;
   logic [15:0]               quo_ff, quo_in;
   logic                      sat_ff, sat_in;

   logic [16:0] trial;
   logic [16:0] diff;
   logic        fits;

   assign trial = {rem_ff, num_ff[DIVIDEND_WIDTH-1]};
   assign diff  = trial - {1'b0, divisor};
   assign fits  = trial >= {1'b0, divisor};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      num_in  = num_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      sat_in  = sat_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_WIDTH'(DIVIDEND_WIDTH);
         num_in  = dividend;
         rem_in  = '0;
         quo_in  = '0;
         sat_in  = 1'b0;
      end else if (busy_ff) begin
         num_in = {num_ff[DIVIDEND_WIDTH-2:0], 1'b0};
         rem_in = fits ? diff[15:0] : trial[15:0];
         quo_in = {quo_ff[14:0], fits};
         // a bit leaving the top means the quotient exceeds 16 bits
         sat_in = sat_ff | quo_ff[15];
         cnt_in = cnt_ff - CNT_WIDTH'(1);
         if (cnt_ff == CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      sat_ff <= sat_in;
   end

   assign done     = done_ff;
   assign quotient = sat_ff ? essm_pkg::RPM_MAX : quo_ff;

endmodule

>>> design/encoder_speed_stall_monitor.sv
// ----------------------------------------------------------------------------
// encoder_speed_stall_monitor
// encoder speed measurement with stall and direction plausibility faults
// ----------------------------------------------------------------------------
// channel  dir   payload                  transfer
// req      in    essm_pkg::req_type       req_valid & req_ready
// rsp      out   essm_pkg::rsp_type       rsp_valid & rsp_ready
// csr      in    csr_index, csr_data      csr_valid & csr_ready (always ready)
//
// a result is formed by the bit-serial divider, which takes one of the
// COUNT_WIDTH + 13 bits of delta*6000 per cycle; a new input is taken only
// once the previous item has left the divider and been loaded into rsp.
// a new item is taken while the previous result still waits on rsp.
// reset is synchronous; registers return to their documented defaults.
// a stalled rsp holds the finished quotient in the divider until taken.
// ----------------------------------------------------------------------------
module encoder_speed_stall_monitor #(
   parameter int COUNT_WIDTH = 32
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  essm_pkg::req_type                      req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output essm_pkg::rsp_type                      rsp_data,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [essm_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [15:0]                            csr_data
);

   localparam int DIVIDEND_WIDTH = COUNT_WIDTH + int'(essm_pkg::SCALE_WIDTH);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_DIV   = 2'd2;
   localparam logic [1:0] ST_HOLD  = 2'd3;

   logic [1:0] state_ff, state_in;

   // configuration
   logic [15:0] ppr_ff, ppr_in;
   logic [15:0] stall_min_pwm_ff, stall_min_pwm_in;
   logic [7:0]  stall_checks_ff, stall_checks_in;
   logic [7:0]  dir_checks_ff, dir_checks_in;
   logic [7:0]  stall_grace_ticks_ff, stall_grace_ticks_in;
   logic [7:0]  dir_grace_ticks_ff, dir_grace_ticks_in;

   // monitor state
   logic [COUNT_WIDTH-1:0] last_count_ff, last_count_in;
   logic [1:0]             last_cmd_ff, last_cmd_in;
   logic [7:0]             stall_count_ff, stall_count_in;
   logic                   stall_latched_ff, stall_latched_in;
   logic [7:0]             mismatch_count_ff, mismatch_count_in;
   logic                   dir_latched_ff, dir_latched_in;
   logic [7:0]             stall_grace_ff, stall_grace_in;
   logic [7:0]             dir_grace_ff, dir_grace_in;

   // item in flight
   logic [COUNT_WIDTH-1:0] delta_ff, delta_in;
   logic [1:0]             enc_dir_ff, enc_dir_in;
   logic [1:0]             cmd_dir_ff, cmd_dir_in;
   logic [15:0]            pwm_ff, pwm_in;

   logic              rsp_valid_ff, rsp_valid_in;
   essm_pkg::rsp_type rsp_ff, rsp_in;

   logic                      req_xfer;
   logic                      rsp_free;
   logic                      load_rsp;
   logic [COUNT_WIDTH-1:0]    cur_count;
   logic                      delta_zero;
   logic                      reversal;
   logic [7:0]                stall_grace_eff;
   logic [7:0]                dir_grace_eff;
   logic [7:0]                stall_count_inc;
   logic [7:0]                mismatch_inc;
   logic                      stall_cond;
   logic                      mismatch_cond;
   logic                      div_start;
   logic [DIVIDEND_WIDTH-1:0] dividend;
   logic                      div_done;
   logic [15:0]               div_quotient;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;

   assign cur_count  = req_data.encoder_count[COUNT_WIDTH-1:0];
   assign delta_zero = (delta_ff == '0);

   // reversal: command moves between two non-stop codes
   assign reversal = (cmd_dir_ff != last_cmd_ff) && (last_cmd_ff != essm_pkg::DIR_STOP)
                     && (cmd_dir_ff != essm_pkg::DIR_STOP);
   assign stall_grace_eff = reversal ? stall_grace_ticks_ff : stall_grace_ff;
   assign dir_grace_eff   = reversal ? dir_grace_ticks_ff : dir_grace_ff;

   assign stall_count_inc = (stall_count_ff == essm_pkg::CHECK_MAX) ? stall_count_ff
                                                                     : stall_count_ff + 8'd1;
   assign mismatch_inc    = (mismatch_count_ff == essm_pkg::CHECK_MAX) ? mismatch_count_ff
                                                                        : mismatch_count_ff + 8'd1;

   assign stall_cond    = (pwm_ff > stall_min_pwm_ff) && delta_zero;
   assign mismatch_cond = (cmd_dir_ff != enc_dir_ff) && (cmd_dir_ff != essm_pkg::DIR_STOP)
                          && !delta_zero;

   assign div_start = (state_ff == ST_CHECK);
   assign dividend  = DIVIDEND_WIDTH'(delta_ff) * DIVIDEND_WIDTH'(essm_pkg::RPM_SCALE);

   essm_div #(
      .DIVIDEND_WIDTH(DIVIDEND_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (ppr_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      state_in             = state_ff;
      ppr_in               = ppr_ff;
      stall_min_pwm_in     = stall_min_pwm_ff;
      stall_checks_in      = stall_checks_ff;
      dir_checks_in        = dir_checks_ff;
      stall_grace_ticks_in = stall_grace_ticks_ff;
      dir_grace_ticks_in   = dir_grace_ticks_ff;
      last_count_in        = last_count_ff;
      last_cmd_in          = last_cmd_ff;
      stall_count_in       = stall_count_ff;
      stall_latched_in     = stall_latched_ff;
      mismatch_count_in    = mismatch_count_ff;
      dir_latched_in       = dir_latched_ff;
      stall_grace_in       = stall_grace_ff;
      dir_grace_in         = dir_grace_ff;
      delta_in             = delta_ff;
      enc_dir_in           = enc_dir_ff;
      cmd_dir_in           = cmd_dir_ff;
      pwm_in               = pwm_ff;
      load_rsp             = 1'b0;

      if (csr_valid) begin
         unique case (csr_index)
            essm_pkg::CSR_PULSES_PER_REV:    ppr_in               = csr_data;
            essm_pkg::CSR_STALL_MIN_PWM:     stall_min_pwm_in     = csr_data;
            essm_pkg::CSR_STALL_CHECKS:      stall_checks_in      = csr_data[7:0];
            essm_pkg::CSR_DIR_CHECKS:        dir_checks_in        = csr_data[7:0];
            essm_pkg::CSR_STALL_GRACE_TICKS: stall_grace_ticks_in = csr_data[7:0];
            essm_pkg::CSR_DIR_GRACE_TICKS:   dir_grace_ticks_in   = csr_data[7:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               // wraparound delta in the counter's own width
               delta_in      = cur_count - last_count_ff;
               last_count_in = cur_count;
               enc_dir_in    = req_data.shaft_dir;
               cmd_dir_in    = req_data.drive_dir;
               pwm_in        = req_data.pwm_echo;
               state_in      = ST_CHECK;
            end
         end
         ST_CHECK: begin
            last_cmd_in    = cmd_dir_ff;
            stall_grace_in = stall_grace_eff;
            dir_grace_in   = dir_grace_eff;
            // a latched check no longer counts down its grace counter, which still reloads on a reversal
            if (!stall_latched_ff) begin
               if (stall_grace_eff != 8'd0) begin
                  stall_grace_in = stall_grace_eff - 8'd1;
               end else if (stall_cond) begin
                  stall_count_in = stall_count_inc;
                  if (stall_count_inc >= stall_checks_ff) begin
                     stall_latched_in = 1'b1;
                  end
               end else if (!delta_zero) begin
                  stall_count_in = '0;
               end
            end
            if (!dir_latched_ff) begin
               if (dir_grace_eff != 8'd0) begin
                  dir_grace_in = dir_grace_eff - 8'd1;
               end else if (mismatch_cond) begin
                  mismatch_count_in = mismatch_inc;
                  if (mismatch_inc >= dir_checks_ff) begin
                     dir_latched_in = 1'b1;
                  end
               end else begin
                  mismatch_count_in = '0;
               end
            end
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) begin
               if (rsp_free) begin
                  load_rsp = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_HOLD;
               end
            end
         end
         ST_HOLD: begin
            if (rsp_free) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      if (load_rsp) begin
         rsp_valid_in           = 1'b1;
         // a zero divisor would give all ones for a zero delta
         rsp_in.speed_rpm       = delta_zero ? 16'd0 : div_quotient;
         rsp_in.measured_dir    = enc_dir_ff;
         rsp_in.stall_fault     = stall_latched_ff;
         rsp_in.direction_fault = dir_latched_ff;
         rsp_in.motor_enable    = !(stall_latched_ff || dir_latched_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff             <= ST_IDLE;
         ppr_ff               <= essm_pkg::RST_PULSES_PER_REV;
         stall_min_pwm_ff     <= essm_pkg::RST_STALL_MIN_PWM;
         stall_checks_ff      <= essm_pkg::RST_STALL_CHECKS;
         dir_checks_ff        <= essm_pkg::RST_DIR_CHECKS;
         stall_grace_ticks_ff <= essm_pkg::RST_STALL_GRACE_TICKS;
         dir_grace_ticks_ff   <= essm_pkg::RST_DIR_GRACE_TICKS;
         last_count_ff        <= '0;
         last_cmd_ff          <= essm_pkg::DIR_STOP;
         stall_count_ff       <= '0;
         stall_latched_ff     <= 1'b0;
         mismatch_count_ff    <= '0;
         dir_latched_ff       <= 1'b0;
         stall_grace_ff       <= '0;
         dir_grace_ff         <= '0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         state_ff             <= state_in;
         ppr_ff               <= ppr_in;
         stall_min_pwm_ff     <= stall_min_pwm_in;
         stall_checks_ff      <= stall_checks_in;
         dir_checks_ff        <= dir_checks_in;
         stall_grace_ticks_ff <= stall_grace_ticks_in;
         dir_grace_ticks_ff   <= dir_grace_ticks_in;
         last_count_ff        <= last_count_in;
         last_cmd_ff          <= last_cmd_in;
         stall_count_ff       <= stall_count_in;
         stall_latched_ff     <= stall_latched_in;
         mismatch_count_ff    <= mismatch_count_in;
         dir_latched_ff       <= dir_latched_in;
         stall_grace_ff       <= stall_grace_in;
         dir_grace_ff         <= dir_grace_in;
         rsp_valid_ff         <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      delta_ff   <= delta_in;
      enc_dir_ff <= enc_dir_in;
      cmd_dir_ff <= cmd_dir_in;
      pwm_ff     <= pwm_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> design/essm_checker.sv
// ----------------------------------------------------------------------------
// essm_checker
// port-level checks of the encoder speed and stall monitor
// ----------------------------------------------------------------------------
`include "encoder_speed_stall_monitor_defines.svh"

module essm_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input essm_pkg::rsp_type rsp_data
);

   logic [1:0] pending_ff, pending_in;
   logic       stall_seen_ff, stall_seen_in;
   logic       dir_seen_ff, dir_seen_in;
   logic       req_xfer;
   logic       rsp_xfer;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid && rsp_ready;

   // items taken in whose result has not yet been transferred out
   always_comb begin
      pending_in = pending_ff;
      if (req_xfer && !rsp_xfer) begin
         pending_in = pending_ff + 2'd1;
      end else if (!req_xfer && rsp_xfer) begin
         pending_in = pending_ff - 2'd1;
      end
      stall_seen_in = stall_seen_ff || (rsp_xfer && rsp_data.stall_fault);
      dir_seen_in   = dir_seen_ff || (rsp_xfer && rsp_data.direction_fault);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff    <= '0;
         stall_seen_ff <= 1'b0;
         dir_seen_ff   <= 1'b0;
      end else begin
         pending_ff    <= pending_in;
         stall_seen_ff <= stall_seen_in;
         dir_seen_ff   <= dir_seen_in;
      end
   end

   `ESSM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `ESSM_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, !rsp_valid)
   `ESSM_ASSERT_SAME(a_rsp_has_item, clock, reset, rsp_valid, pending_ff != 2'd0)
   `ESSM_ASSERT_SAME(a_stall_sticky, clock, reset, rsp_valid && stall_seen_ff, rsp_data.stall_fault)
   `ESSM_ASSERT_SAME(a_dir_sticky, clock, reset, rsp_valid && dir_seen_ff, rsp_data.direction_fault)

endmodule

bind encoder_speed_stall_monitor essm_checker u_essm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
